// File: hw/rtl/sew_pkg.sv
package sew_pkg;

  // Frame geometry limits
  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned RowW      = $clog2(MaxHeight);

  // Register and data widths
  localparam int unsigned WidthRegW  = 11;
  localparam int unsigned HeightRegW = 13;
  localparam int unsigned ThreshW    = 8;
  localparam int unsigned CfgDataW   = 13;
  localparam int unsigned PixW       = 8;
  localparam int unsigned SumW       = 12;
  localparam int unsigned LineWordW  = 2 * PixW;

  // Register reset values
  localparam logic [WidthRegW-1:0]  WidthReset  = 11'd640;
  localparam logic [HeightRegW-1:0] HeightReset = 13'd480;
  localparam logic [16:0]           ThrSqReset  = 17'd22801; // (150 + 1)^2

  localparam logic signed [SumW-1:0] ScaleBias = 12'sd765;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_EDGE_THRESH  = 2'd2
  } sew_reg_e;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            flush;
  } sew_in_t;

  typedef struct packed {
    logic edge_res;
    logic last_of_frame;
  } sew_out_t;

  typedef struct packed {
    logic                we;
    logic [1:0]          idx;
    logic [CfgDataW-1:0] data;
  } sew_cfg_t;

  // Control word handed from the counters to the window stage
  typedef struct packed {
    logic            emit;
    logic            last;
    logic            border;
    logic [PixW-1:0] pix;
    logic [ColW-1:0] col;
  } sew_s1_t;

  // Gradient pair handed to the threshold stage
  typedef struct packed {
    logic            last;
    logic [PixW-1:0] x;
    logic [PixW-1:0] y;
  } sew_s2_t;

  // (sum + 765) / 8 truncated toward zero, low 8 bits kept
  function automatic logic [PixW-1:0] scale_sum(input logic signed [SumW-1:0] s);
    logic signed [SumW-1:0] v;
    logic [SumW-1:0]        mag;
    logic [SumW-1:0]        q;
    v = s + ScaleBias;
    if (v[SumW-1]) begin
      mag = SumW'(-v);
      q   = SumW'(0) - (mag >> 3);
    end else begin
      q = SumW'(v) >> 3;
    end
    return q[PixW-1:0];
  endfunction

endpackage

// File: hw/rtl/sew_ram.sv
module sew_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/sew_ctrl.sv
module sew_ctrl import sew_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sew_cfg_t        cfg_i,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  sew_in_t         in_word_i,
  output logic            restart_o,
  output logic            s1_load_o,
  output sew_s1_t         s1_o,
  output logic            rd_en_o,
  output logic [ColW-1:0] rd_addr_o
);

  logic [WidthRegW-1:0]  w_q, w_d;
  logic [HeightRegW-1:0] h_q, h_d;
  logic [ColW-1:0]       ci_q, ci_d;
  logic [RowW-1:0]       row_q, row_d;
  logic [ColW-1:0]       ocol_q, ocol_d;
  logic [RowW-1:0]       orow_q, orow_d;
  logic                  drain_q, drain_d;

  logic                  accept, active, emit, border, last;
  logic                  o_last_col, o_last_row, i_last_col, i_last_row;
  logic [WidthRegW-1:0]  wm1;
  logic [HeightRegW-1:0] hm1;
  logic [WidthRegW-1:0]  cfg_w;
  logic [HeightRegW-1:0] cfg_h;

  assign accept    = in_valid_i && in_ready_i;
  // a flush is only meaningful once the whole frame is in
  assign active    = drain_q || !in_word_i.flush;
  assign restart_o = cfg_i.we && (cfg_i.idx == REG_FRAME_WIDTH || cfg_i.idx == REG_FRAME_HEIGHT);

  assign wm1 = w_q - WidthRegW'(1);
  assign hm1 = h_q - HeightRegW'(1);

  // output position decode
  assign o_last_col = (WidthRegW'(ocol_q) == wm1);
  assign o_last_row = (HeightRegW'(orow_q) == hm1);
  assign border     = (orow_q == '0) || o_last_row || (ocol_q == '0) || o_last_col;
  assign last       = o_last_row && o_last_col;

  // input position decode
  assign i_last_col = (WidthRegW'(ci_q) == wm1);
  assign i_last_row = (HeightRegW'(row_q) == hm1);
  assign emit       = drain_q || (row_q >= RowW'(2)) || (row_q == RowW'(1) && ci_q != '0);

  // clamped geometry from the config word
  always_comb begin
    cfg_w = cfg_i.data[WidthRegW-1:0];
    if (cfg_w < WidthRegW'(3)) begin
      cfg_w = WidthRegW'(3);
    end else if (cfg_w > WidthRegW'(MaxWidth)) begin
      cfg_w = WidthRegW'(MaxWidth);
    end
    cfg_h = cfg_i.data[HeightRegW-1:0];
    if (cfg_h < HeightRegW'(3)) begin
      cfg_h = HeightRegW'(3);
    end else if (cfg_h > HeightRegW'(MaxHeight)) begin
      cfg_h = HeightRegW'(MaxHeight);
    end
  end

  // position counters
  always_comb begin
    w_d     = w_q;
    h_d     = h_q;
    ci_d    = ci_q;
    row_d   = row_q;
    ocol_d  = ocol_q;
    orow_d  = orow_q;
    drain_d = drain_q;
    if (restart_o) begin
      if (cfg_i.idx == REG_FRAME_WIDTH) begin
        w_d = cfg_w;
      end else begin
        h_d = cfg_h;
      end
      ci_d    = '0;
      row_d   = '0;
      ocol_d  = '0;
      orow_d  = '0;
      drain_d = 1'b0;
    end else if (accept && active) begin
      if (emit && last) begin
        ci_d    = '0;
        row_d   = '0;
        ocol_d  = '0;
        orow_d  = '0;
        drain_d = 1'b0;
      end else begin
        if (emit) begin
          if (o_last_col) begin
            ocol_d = '0;
            orow_d = orow_q + RowW'(1);
          end else begin
            ocol_d = ocol_q + ColW'(1);
          end
        end
        if (i_last_col) begin
          ci_d = '0;
          if (!drain_q) begin
            if (i_last_row) begin
              row_d   = '0;
              drain_d = 1'b1;
            end else begin
              row_d = row_q + RowW'(1);
            end
          end
        end else begin
          ci_d = ci_q + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q     <= WidthReset;
      h_q     <= HeightReset;
      ci_q    <= '0;
      row_q   <= '0;
      ocol_q  <= '0;
      orow_q  <= '0;
      drain_q <= 1'b0;
    end else begin
      w_q     <= w_d;
      h_q     <= h_d;
      ci_q    <= ci_d;
      row_q   <= row_d;
      ocol_q  <= ocol_d;
      orow_q  <= orow_d;
      drain_q <= drain_d;
    end
  end

  // word into the window stage; line stores read at the same column
  assign s1_load_o   = accept && active;
  assign s1_o.emit   = emit;
  assign s1_o.last   = emit && last;
  assign s1_o.border = border;
  assign s1_o.pix    = drain_q ? '0 : in_word_i.pixel;
  assign s1_o.col    = ci_q;
  assign rd_en_o     = accept && active;
  assign rd_addr_o   = ci_q;

endmodule

// File: hw/rtl/sew_window.sv
module sew_window import sew_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 restart_i,
  input  logic                 s1_load_i,
  input  sew_s1_t              s1_i,
  output logic                 s1_free_o,
  input  logic [LineWordW-1:0] rd_data_i,
  output logic                 wr_en_o,
  output logic [ColW-1:0]      wr_addr_o,
  output logic [LineWordW-1:0] wr_data_o,
  input  logic                 s2_free_i,
  output logic                 s2_load_o,
  output sew_s2_t              s2_o
);

  logic            s1_valid_q;
  sew_s1_t         s1_q;
  logic [PixW-1:0] win_q [6];
  logic            go;
  logic [PixW-1:0] nt, nm, nb;

  logic signed [SumW-1:0] l0, l1, l2, m0, m2, r0, r1, r2;
  logic signed [SumW-1:0] sx, sy;

  assign go        = s1_valid_q && (!s1_q.emit || s2_free_i);
  assign s1_free_o = !s1_valid_q || go;

  // stage register; read data from the line store lines up with it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free_o) begin
      s1_valid_q <= s1_load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free_o && s1_load_i) begin
      s1_q <= s1_i;
    end
  end

  // new column: upper and middle rows from the line store, bottom is the pixel
  assign nt = rd_data_i[LineWordW-1:PixW];
  assign nm = rd_data_i[PixW-1:0];
  assign nb = s1_q.pix;

  assign l0 = $signed({4'b0, win_q[0]});
  assign l1 = $signed({4'b0, win_q[1]});
  assign l2 = $signed({4'b0, win_q[2]});
  assign m0 = $signed({4'b0, win_q[3]});
  assign m2 = $signed({4'b0, win_q[5]});
  assign r0 = $signed({4'b0, nt});
  assign r1 = $signed({4'b0, nm});
  assign r2 = $signed({4'b0, nb});

  // Sobel sums
  assign sx = (r0 - l0) + ((r1 - l1) <<< 1) + (r2 - l2);
  assign sy = (l0 + (m0 <<< 1) + r0) - (l2 + (m2 <<< 1) + r2);

  // border pixels pass the centre through as both gradients
  assign s2_load_o = go && s1_q.emit;
  assign s2_o.last = s1_q.last;
  assign s2_o.x    = s1_q.border ? win_q[4] : scale_sum(sx);
  assign s2_o.y    = s1_q.border ? win_q[4] : scale_sum(sy);

  // window shift; cleared at the end of a frame or on a geometry write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (restart_i || (go && s1_q.last)) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (go) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= nt;
      win_q[4] <= nm;
      win_q[5] <= nb;
    end
  end

  // line store write back: middle moves up, pixel becomes middle
  assign wr_en_o   = go && !s1_q.last;
  assign wr_addr_o = s1_q.col;
  assign wr_data_o = {nm, nb};

endmodule

// File: hw/rtl/sew_decide.sv
module sew_decide import sew_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  sew_cfg_t cfg_i,
  input  logic     s2_load_i,
  input  sew_s2_t  s2_i,
  output logic     s2_free_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output sew_out_t out_word_o
);

  logic        s2_valid_q;
  sew_s2_t     s2_q;
  logic        o_valid_q;
  sew_out_t    o_q;
  logic [16:0] thr_sq_q, thr_sq_d;
  logic        never_q, never_d;
  logic [8:0]  t1;
  logic        o_free, s2_go, is_edge;
  logic [15:0] xx, yy;
  logic [16:0] mag_sq;

  // threshold kept as (threshold + 1)^2; 255 can never be exceeded
  assign t1       = {1'b0, cfg_i.data[ThreshW-1:0]} + 9'd1;
  assign thr_sq_d = 17'(t1) * 17'(t1);
  assign never_d  = (cfg_i.data[ThreshW-1:0] == 8'hFF);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_sq_q <= ThrSqReset;
      never_q  <= 1'b0;
    end else if (cfg_i.we && cfg_i.idx == REG_EDGE_THRESH) begin
      thr_sq_q <= thr_sq_d;
      never_q  <= never_d;
    end
  end

  // handshake between gradient stage and output register
  assign o_free    = !o_valid_q || out_ready_i;
  assign s2_go     = s2_valid_q && o_free;
  assign s2_free_o = !s2_valid_q || s2_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      o_valid_q  <= 1'b0;
    end else begin
      if (s2_free_o) begin
        s2_valid_q <= s2_load_i;
      end
      if (o_free) begin
        o_valid_q <= s2_go;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free_o && s2_load_i) begin
      s2_q <= s2_i;
    end
  end

  // squared magnitude against the squared threshold
  assign xx      = {8'b0, s2_q.x} * {8'b0, s2_q.x};
  assign yy      = {8'b0, s2_q.y} * {8'b0, s2_q.y};
  assign mag_sq  = {1'b0, xx} + {1'b0, yy};
  assign is_edge = !never_q && (mag_sq >= thr_sq_q);

  always_ff @(posedge clk_i) begin
    if (s2_go) begin
      o_q.edge_res      <= is_edge;
      o_q.last_of_frame <= s2_q.last;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_word_o  = o_q;

endmodule

// File: hw/rtl/sobel_edge_threshold.sv
// Sobel edge detector with a magnitude threshold, one gray pixel per word.
// Input channel (in_valid_i / in_ready_o / in_word_i) takes pixels in raster
// order; a word with flush set carries no pixel and only pushes out the
// results still pending once the whole frame is in. Output channel
// (out_valid_o / out_ready_i / out_word_o) gives one edge/background word per
// pixel, last_of_frame marking the final one. Results trail the input by one
// row plus one pixel, so a frame of W x H pixels needs W + 1 flush words.
// The word that releases a result passes the window stage (line store read)
// and the threshold stage, then reaches the output register. Throughput is
// one word per cycle unless the receiver stalls: each word makes one read
// and one write of the single line store RAM, at different columns.
// The config port (cfg_we_i, cfg_idx_i, cfg_data_i) writes frame width,
// frame height and threshold; a geometry write restarts the frame. Write it
// only while nothing is in flight. Reset sets 640 x 480, threshold 150, and
// an empty pipeline; the line store needs no clearing. When the receiver
// stalls, words hold in the output register and pipeline stages and
// in_ready_o falls once all stages are full.
module sobel_edge_threshold import sew_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sew_in_t             in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sew_out_t            out_word_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  sew_cfg_t             cfg;
  logic                 restart;
  logic                 s1_load, s1_free;
  sew_s1_t              s1;
  logic                 s2_load, s2_free;
  sew_s2_t              s2;
  logic                 rd_en, wr_en;
  logic [ColW-1:0]      rd_addr, wr_addr;
  logic [LineWordW-1:0] rd_data, wr_data;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  assign in_ready_o = s1_free;

  sew_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_i (s1_free),
    .in_word_i  (in_word_i),
    .restart_o  (restart),
    .s1_load_o  (s1_load),
    .s1_o       (s1),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr)
  );

  // upper row in the high byte, middle row in the low byte
  sew_ram #(
    .Depth (MaxWidth),
    .Width (LineWordW)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  sew_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart),
    .s1_load_i (s1_load),
    .s1_i      (s1),
    .s1_free_o (s1_free),
    .rd_data_i (rd_data),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .s2_free_i (s2_free),
    .s2_load_o (s2_load),
    .s2_o      (s2)
  );

  sew_decide u_decide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .s2_load_i   (s2_load),
    .s2_i        (s2),
    .s2_free_o   (s2_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

// File: bench/tb_sobel_edge_threshold.sv
`timescale 1ns / 1ps

module tb_sobel_edge_threshold;
  import sew_pkg::*;

  // idle cycles granted after the last result: three stages plus margin
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned RandomWords  = 750;
  localparam int unsigned HoldCycles   = 300;

  typedef enum bit {
    ROW_WORD,
    ROW_REG
  } row_kind_e;

  // one line of the directed plan: a register write or an input word
  typedef struct {
    row_kind_e           kind;
    sew_reg_e            reg_idx;
    logic [CfgDataW-1:0] reg_val;
    sew_in_t             word;
    bit                  fixed;
    sew_out_t            res;
  } plan_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  sew_in_t             in_word_i;
  logic                out_valid_o;
  logic                out_ready_i;
  sew_out_t            out_word_o;
  logic                cfg_we_i;
  logic [1:0]          cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  sobel_edge_threshold u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Mirror of the detector state
  logic [PixW-1:0] upper_row  [MaxWidth];
  logic [PixW-1:0] middle_row [MaxWidth];
  logic [PixW-1:0] win_px     [6];
  int unsigned     col_in;
  int unsigned     row_in;
  int unsigned     pos_out;
  bit              flushing;
  int unsigned     cfg_width;
  int unsigned     cfg_height;
  int unsigned     cfg_thresh;

  sew_out_t    due_marks [$];
  plan_row_t   plan_rows [$];
  int unsigned mark_errors;
  int unsigned words_sent;
  bit          tx_steady;
  bit          rx_steady;
  bit          hold_request;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_frame();
    foreach (win_px[i]) win_px[i] = '0;
    col_in   = 0;
    row_in   = 0;
    pos_out  = 0;
    flushing = 1'b0;
  endfunction

  // SV integer division truncates toward zero; keep the low byte
  function automatic logic [PixW-1:0] grad_scale(int s);
    int v;
    v = s + 765;
    return PixW'(v / 8);
  endfunction

  function automatic bit is_edge(int unsigned xg, int unsigned yg);
    if (cfg_thresh >= 255) return 1'b0;
    return (xg * xg + yg * yg) >= (cfg_thresh + 1) * (cfg_thresh + 1);
  endfunction

  // Advance the mirror by one accepted word; returns 1 when a result is due
  function automatic bit predict_mark(input sew_in_t w, output sew_out_t res);
    int unsigned wd, ht, ci, nt, nm, nb, orow, ocol, xg, yg;
    int          l0, l1, l2, m0, m2, sx, sy;
    bit          fire, is_last;
    wd  = clamp_dim(cfg_width, MaxWidth);
    ht  = clamp_dim(cfg_height, MaxHeight);
    ci  = (col_in >= wd) ? 0 : col_in;
    res = '0;
    // early flush is ignored outright
    if (!flushing && w.flush) return 1'b0;
    nb   = flushing ? 0 : w.pixel;
    nt   = upper_row[ci];
    nm   = middle_row[ci];
    fire = flushing || row_in >= 2 || (row_in == 1 && ci >= 1);
    if (fire) begin
      orow    = pos_out / wd;
      ocol    = pos_out % wd;
      is_last = (pos_out == wd * ht - 1);
      if (orow == 0 || orow >= ht - 1 || ocol == 0 || ocol == wd - 1) begin
        xg = win_px[4];
        yg = win_px[4];
      end else begin
        l0 = win_px[0];
        l1 = win_px[1];
        l2 = win_px[2];
        m0 = win_px[3];
        m2 = win_px[5];
        sx = (int'(nt) - l0) + 2 * (int'(nm) - l1) + (int'(nb) - l2);
        sy = (l0 + 2 * m0 + int'(nt)) - (l2 + 2 * m2 + int'(nb));
        xg = grad_scale(sx);
        yg = grad_scale(sy);
      end
      res.edge_res      = is_edge(xg, yg);
      res.last_of_frame = is_last;
      if (is_last) begin
        restart_frame();
        return 1'b1;
      end
      pos_out++;
    end
    // shift the window, roll the line stores
    win_px[0] = win_px[3];
    win_px[1] = win_px[4];
    win_px[2] = win_px[5];
    win_px[3] = PixW'(nt);
    win_px[4] = PixW'(nm);
    win_px[5] = PixW'(nb);
    upper_row[ci]  = PixW'(nm);
    middle_row[ci] = PixW'(nb);
    ci++;
    if (ci >= wd) begin
      ci = 0;
      if (!flushing) begin
        row_in++;
        if (row_in >= ht) begin
          row_in   = 0;
          flushing = 1'b1;
        end
      end
    end
    col_in = ci;
    return fire;
  endfunction

  function automatic void plan_word(logic [PixW-1:0] px, bit fl, bit fixed, bit mark,
                                    bit is_last);
    plan_row_t r;
    r.kind                = ROW_WORD;
    r.reg_idx             = REG_FRAME_WIDTH;
    r.reg_val             = '0;
    r.word.pixel          = px;
    r.word.flush          = fl;
    r.fixed               = fixed;
    r.res.edge_res        = mark;
    r.res.last_of_frame   = is_last;
    plan_rows.push_back(r);
  endfunction

  function automatic void plan_reg(sew_reg_e idx, logic [CfgDataW-1:0] val);
    plan_row_t r;
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    r.word    = '0;
    r.fixed   = 1'b0;
    r.res     = '0;
    plan_rows.push_back(r);
  endfunction

  function automatic int unsigned pick_thresh();
    case ($urandom_range(4))
      0:       return 0;
      1:       return 255;
      2:       return 254;
      3:       return $urandom_range(90, 180);
      default: return $urandom_range(255);
    endcase
  endfunction

  function automatic logic [PixW-1:0] make_pixel(int unsigned style, int unsigned row,
                                                 int unsigned col, int unsigned base);
    int v;
    case (style)
      0: return PixW'($urandom_range(255));
      // checkerboard of 2x2 blocks with the odd flipped pixel
      1: begin
        v = ((col / 2 + row / 2) % 2 == 0) ? 255 : 0;
        if ($urandom_range(7) == 0) v = 255 - v;
        return PixW'(v);
      end
      // flat field with light noise
      2: begin
        v = int'(base) + int'($urandom_range(16)) - 8;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return PixW'(v);
      end
      default: return PixW'(col * (base % 32) + row * 23);
    endcase
  endfunction

  // Register write; called at a falling edge while the block is idle
  task automatic write_reg(sew_reg_e idx, logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_FRAME_WIDTH: begin
        cfg_width = val[WidthRegW-1:0];
        restart_frame();
      end
      REG_FRAME_HEIGHT: begin
        cfg_height = val[HeightRegW-1:0];
        restart_frame();
      end
      default: cfg_thresh = val[ThreshW-1:0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Offer one word after a random gap, predict on acceptance
  task automatic send_word(input sew_in_t w, input bit fixed, input sew_out_t fixed_res);
    int unsigned gap;
    sew_out_t    res;
    bit          got;
    gap = tx_steady ? 0 : $urandom_range(10);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    got = predict_mark(w, res);
    if (got) due_marks.push_back(fixed ? fixed_res : res);
    @(negedge clk_i);
  endtask

  // Stop offering and wait for every due result plus the pipeline depth
  task automatic drain_wait();
    in_valid_i <= 1'b0;
    while (due_marks.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Pixels of one frame in raster order up to stop_at, then drain words if the frame is whole
  task automatic run_frame(int wd, int ht, int stop_at, int unsigned style, int retune_at,
                           int hold_at);
    int unsigned base;
    sew_in_t     w;
    base = $urandom_range(255);
    for (int k = 0; k < wd * ht && k < stop_at; k++) begin
      if (k == retune_at) begin
        drain_wait();
        write_reg(REG_EDGE_THRESH, CfgDataW'(pick_thresh()));
      end
      if (k == hold_at) hold_request = 1'b1;
      // stray flush mid-frame: ignored
      if ($urandom_range(40) == 0) begin
        w.pixel = PixW'($urandom);
        w.flush = 1'b1;
        send_word(w, 1'b0, '0);
      end
      w.pixel = make_pixel(style, k / wd, k % wd, base);
      w.flush = 1'b0;
      send_word(w, 1'b0, '0);
      words_sent++;
    end
    if (stop_at >= wd * ht) begin
      // pixels during the drain are dropped, so mix them in
      for (int i = 0; i <= wd; i++) begin
        w.pixel = PixW'($urandom);
        w.flush = ($urandom_range(3) != 0);
        send_word(w, 1'b0, '0);
        words_sent++;
      end
    end
  endtask

  // Result side: random stalls, one long hold on request
  initial begin
    int unsigned stall;
    sew_out_t    want;
    out_ready_i = 1'b0;
    rx_steady   = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      if ($urandom_range(30) == 0) rx_steady = !rx_steady;
      stall = rx_steady ? 0 : $urandom_range(10);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (due_marks.size() == 0) begin
        $error("result word with nothing due: edge_res=%0b last_of_frame=%0b",
               out_word_o.edge_res, out_word_o.last_of_frame);
        mark_errors++;
      end else begin
        want = due_marks.pop_front();
        if (out_word_o.edge_res !== want.edge_res) begin
          $error("edge_res: expected %0b, got %0b", want.edge_res, out_word_o.edge_res);
          mark_errors++;
        end
        if (out_word_o.last_of_frame !== want.last_of_frame) begin
          $error("last_of_frame: expected %0b, got %0b", want.last_of_frame,
                 out_word_o.last_of_frame);
          mark_errors++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #2000000;
    $display("sobel_edge_threshold: mismatch");
    $finish;
  end

  initial begin
    int wd_raw, ht_raw, wd, ht, stop_at, retune_at;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_word_i    = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_FRAME_WIDTH;
    cfg_data_i   = '0;
    tx_steady    = 1'b0;
    hold_request = 1'b0;
    mark_errors  = 0;
    words_sent   = 0;
    cfg_width    = 640;
    cfg_height   = 480;
    cfg_thresh   = 150;
    foreach (upper_row[i]) begin
      upper_row[i]  = '0;
      middle_row[i] = '0;
    end
    restart_frame();

    // 3x3 frame at the reset threshold of 150: a border pixel is an
    // edge from 107 up; the centre pixel goes through the predictor
    plan_word(8'd0, 1'b1, 1'b0, 1'b0, 1'b0); // flush into an empty frame
    plan_reg(REG_FRAME_WIDTH, 13'd0);        // clamps up to 3
    plan_reg(REG_FRAME_HEIGHT, 13'd2);       // clamps up to 3
    plan_word(8'd107, 1'b0, 1'b0, 1'b0, 1'b0);
    plan_word(8'd106, 1'b0, 1'b0, 1'b0, 1'b0);
    plan_word(8'd255, 1'b0, 1'b0, 1'b0, 1'b0);
    plan_word(8'd0,   1'b0, 1'b0, 1'b0, 1'b0);
    plan_word(8'd90,  1'b0, 1'b1, 1'b1, 1'b0);
    plan_word(8'd255, 1'b0, 1'b1, 1'b0, 1'b0);
    plan_word(8'd255, 1'b0, 1'b1, 1'b1, 1'b0);
    plan_word(8'd0,   1'b0, 1'b1, 1'b0, 1'b0);
    plan_word(8'd107, 1'b0, 1'b0, 1'b0, 1'b0);
    plan_word(8'hff,  1'b1, 1'b1, 1'b1, 1'b0);
    plan_word(8'd200, 1'b0, 1'b1, 1'b1, 1'b0); // pixel while draining
    plan_word(8'd0,   1'b1, 1'b1, 1'b0, 1'b0);
    plan_word(8'd0,   1'b1, 1'b1, 1'b1, 1'b1);
    // threshold 255: nothing can be an edge
    plan_reg(REG_EDGE_THRESH, 13'd255);
    for (int i = 0; i < 9; i++) begin
      plan_word((i % 2 == 0) ? 8'd255 : 8'd0, 1'b0, i >= 4, 1'b0, 1'b0);
    end
    plan_word(8'd0, 1'b1, 1'b1, 1'b0, 1'b0);
    plan_word(8'd0, 1'b1, 1'b1, 1'b0, 1'b0);
    plan_word(8'd0, 1'b1, 1'b1, 1'b0, 1'b0);
    plan_word(8'd0, 1'b1, 1'b1, 1'b0, 1'b1);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan_rows[i]) begin
      if (plan_rows[i].kind == ROW_REG) begin
        drain_wait();
        write_reg(plan_rows[i].reg_idx, plan_rows[i].reg_val);
      end else begin
        send_word(plan_rows[i].word, plan_rows[i].fixed, plan_rows[i].res);
      end
    end

    // widest setting (2047 clamps to 1024): a short run, no result is due
    // before a whole row is in
    drain_wait();
    write_reg(REG_FRAME_WIDTH, 13'h7ff);
    write_reg(REG_FRAME_HEIGHT, 13'd3);
    write_reg(REG_EDGE_THRESH, CfgDataW'($urandom_range(90, 180)));
    run_frame(MaxWidth, 3, 64, 0, -1, -1);

    // tallest setting with a long hold on the result side, cut short by
    // the next geometry write
    drain_wait();
    write_reg(REG_FRAME_WIDTH, 13'd3);
    write_reg(REG_FRAME_HEIGHT, 13'h1fff);
    run_frame(3, MaxHeight, 90, 0, -1, 20);

    // random frames, some cut short, some retuned mid-frame
    while (words_sent < RandomWords) begin
      drain_wait();
      tx_steady = ($urandom_range(3) == 0);
      case ($urandom_range(7))
        0:       wd_raw = $urandom_range(0, 2);
        1:       wd_raw = $urandom_range(13, 48);
        default: wd_raw = $urandom_range(3, 10);
      endcase
      if ($urandom_range(7) == 0) ht_raw = $urandom_range(0, 2);
      else if (wd_raw > 12) ht_raw = $urandom_range(3, 4);
      else ht_raw = $urandom_range(3, 8);
      if ($urandom_range(1) == 0) begin
        write_reg(REG_FRAME_WIDTH, CfgDataW'(wd_raw));
        write_reg(REG_FRAME_HEIGHT, CfgDataW'(ht_raw));
      end else begin
        write_reg(REG_FRAME_HEIGHT, CfgDataW'(ht_raw));
        write_reg(REG_FRAME_WIDTH, CfgDataW'(wd_raw));
      end
      if ($urandom_range(4) != 0) write_reg(REG_EDGE_THRESH, CfgDataW'(pick_thresh()));
      wd        = clamp_dim(wd_raw, MaxWidth);
      ht        = clamp_dim(ht_raw, MaxHeight);
      stop_at   = ($urandom_range(5) == 0) ? $urandom_range(1, wd * ht - 1) : wd * ht;
      retune_at = ($urandom_range(5) == 0) ? $urandom_range(1, wd * ht - 1) : -1;
      run_frame(wd, ht, stop_at, $urandom_range(3), retune_at, -1);
    end

    drain_wait();
    if (mark_errors == 0) begin
      $display("sobel_edge_threshold: match");
    end else begin
      $display("sobel_edge_threshold: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/sew_pkg.sv
hw/rtl/sew_ram.sv
hw/rtl/sew_ctrl.sv
hw/rtl/sew_window.sv
hw/rtl/sew_decide.sv
hw/rtl/sobel_edge_threshold.sv
bench/tb_sobel_edge_threshold.sv
